// ----- src/stack_with_middle_and_half_reverse_top_defines.svh -----
// ----------------------------------------------------------------------------
// stack_with_middle_and_half_reverse_top_defines
// assertion macros for the port-level checker
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_MIDDLE_AND_HALF_REVERSE_TOP_DEFINES_SVH
`define STACK_WITH_MIDDLE_AND_HALF_REVERSE_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define SWM_ASSERT_NOW(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("stack check failed");

// condition implies consequence in the next cycle
`define SWM_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("stack check failed");

`endif

// ----- src/swmhr_pkg.sv -----
// ----------------------------------------------------------------------------
// swmhr_pkg
// shared constants, codes and interface types for the stack block
// ----------------------------------------------------------------------------
`default_nettype none

package swmhr_pkg;

    localparam int STACK_DEPTH   = 16;
    localparam int ADDR_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W        = 32;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 72;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REV  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd3;

    localparam logic [WORD_W-1:0] POP_EMPTY_WORD = '1;

    typedef struct packed {
        logic latch;
        logic exec;
        logic mid_rd;
        logic sw_rd;
        logic sw_wa;
        logic sw_wb;
        logic load_out;
    } swmhr_cmd_t;

    typedef struct packed {
        logic rev_swaps;
        logic more_swaps;
        logic out_free;
    } swmhr_stat_t;

endpackage

`default_nettype wire

// ----- src/stack_with_middle_and_half_reverse_top.sv -----
// ----------------------------------------------------------------------------
// stack_with_middle_and_half_reverse_top
// bounded stack of 32-bit words with middle tap and bottom-half reversal
// ----------------------------------------------------------------------------
// input stream carries one operation per transaction: s_tuser holds the mode
// (push, pop, reverse bottom half), s_tdata the word to push. every input
// transaction yields exactly one result transaction on the m_ side: m_tuser
// holds the status, m_tdata the popped word, the middle entry, its valid flag
// and the entry count.
// m_tvalid rises once an accepted push, pop or rejected operation has passed
// the execute, middle read and result load states; a reversal adds a swap loop
// before the middle read for each swapped pair (read both entries, then two
// writes through the single memory write port), at most STACK_DEPTH/4 pairs.
// one operation is in flight at a time; s_tready is high only while idle, so
// even with the result side ready a new operation is accepted only after the
// previous one, with any swaps of a reversal, has loaded its result.
// a finished result sits in an output register, so the next operation is
// accepted while it waits; if m_tready stays low, the following operation
// halts before its result load until the register frees.
// reset empties the stack and drops m_tvalid; memory contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_middle_and_half_reverse_top
    import swmhr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] push_value
    input  wire logic [MODE_W-1:0]     s_tuser,   // [1:0] mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [31:0] popped_value, [63:32] middle_value,
                                                  // [64] middle_valid, [69:65] entry_count,
                                                  // [71:70] zero
    output logic [STATUS_W-1:0]        m_tuser    // [1:0] status
);

    swmhr_cmd_t                cmd;
    swmhr_stat_t               stat;
    logic [STATUS_W-1:0]       out_status;
    logic [WORD_W-1:0]         out_popped;
    logic [WORD_W-1:0]         out_middle;
    logic                      out_mid_valid;
    logic [ENTRY_COUNT_W-1:0]  out_count;

    swmhr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    swmhr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_mode       (s_tuser),
        .in_value      (s_tdata[WORD_W-1:0]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .out_status    (out_status),
        .out_popped    (out_popped),
        .out_middle    (out_middle),
        .out_mid_valid (out_mid_valid),
        .out_count     (out_count)
    );

    assign m_tuser = out_status;
    assign m_tdata = {(M_TDATA_W - 2*WORD_W - 1 - ENTRY_COUNT_W)'(0),
                      out_count, out_mid_valid, out_middle, out_popped};

endmodule

`default_nettype wire

// ----- src/swmhr_ctrl.sv -----
// ----------------------------------------------------------------------------
// swmhr_ctrl
// operation sequencer: accept, execute, swap loop, middle read, result load
// ----------------------------------------------------------------------------
`default_nettype none

module swmhr_ctrl
    import swmhr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output swmhr_cmd_t       cmd,
    input  wire swmhr_stat_t stat
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_SWRD = 7'b0000100,
        S_SWWA = 7'b0001000,
        S_SWWB = 7'b0010000,
        S_MID  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.rev_swaps ? S_SWRD : S_MID;
            end
            S_SWRD: begin
                cmd.sw_rd  = 1'b1;
                state_next = S_SWWA;
            end
            S_SWWA: begin
                cmd.sw_wa  = 1'b1;
                state_next = S_SWWB;
            end
            S_SWWB: begin
                cmd.sw_wb  = 1'b1;
                state_next = stat.more_swaps ? S_SWRD : S_MID;
            end
            S_MID: begin
                cmd.mid_rd = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/swmhr_dp.sv -----
// ----------------------------------------------------------------------------
// swmhr_dp
// stack memory, entry count, swap pointers and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module swmhr_dp
    import swmhr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire swmhr_cmd_t           cmd,
    output swmhr_stat_t               stat,
    input  wire logic [MODE_W-1:0]    in_mode,
    input  wire logic [WORD_W-1:0]    in_value,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [STATUS_W-1:0]       out_status,
    output logic [WORD_W-1:0]         out_popped,
    output logic [WORD_W-1:0]         out_middle,
    output logic                      out_mid_valid,
    output logic [ENTRY_COUNT_W-1:0]  out_count
);

    logic [WORD_W-1:0]   mem [STACK_DEPTH];
    logic [WORD_W-1:0]   rda_reg, rdb_reg;
    logic [MODE_W-1:0]   op_reg;
    logic [WORD_W-1:0]   val_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                pop_ok_reg, pop_ok_next;
    logic [ADDR_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic                tvalid_reg;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [CNT_W-1:0]    half;
    logic [CNT_W-1:0]    mid_full;
    logic [ADDR_W:0]     lo_inc, hi_dec;

    assign half     = cnt_reg >> 1;
    assign mid_full = (cnt_reg - CNT_W'(1)) >> 1;
    assign lo_inc   = {1'b0, lo_reg} + (ADDR_W+1)'(1);
    assign hi_dec   = {1'b0, hi_reg} - (ADDR_W+1)'(1);

    assign stat.rev_swaps  = (op_reg == MODE_REV) && ({1'b0, cnt_reg} >= (CNT_W+1)'(4));
    assign stat.more_swaps = lo_inc < hi_dec;
    assign stat.out_free   = !tvalid_reg || m_tready;

    // operation execute, count and swap pointers
    always_comb begin
        cnt_next    = cnt_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        wr_en       = 1'b0;
        wr_addr     = lo_reg;
        wr_data     = rdb_reg;
        if (cmd.exec) begin
            status_next = ST_OK;
            pop_ok_next = 1'b0;
            unique case (op_reg)
                MODE_PUSH: begin
                    if (cnt_reg == CNT_W'(STACK_DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[ADDR_W-1:0];
                        wr_data  = val_reg;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                MODE_POP: begin
                    if (cnt_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        pop_ok_next = 1'b1;
                        cnt_next    = cnt_reg - CNT_W'(1);
                    end
                end
                MODE_REV: begin
                    if (cnt_reg < CNT_W'(2)) begin
                        status_next = ST_FEW;
                    end else begin
                        lo_next = '0;
                        hi_next = ADDR_W'(half - CNT_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.sw_wa) begin
            wr_en   = 1'b1;
            wr_addr = lo_reg;
            wr_data = rdb_reg;
        end else if (cmd.sw_wb) begin
            wr_en   = 1'b1;
            wr_addr = hi_reg;
            wr_data = rda_reg;
            lo_next = lo_inc[ADDR_W-1:0];
            hi_next = hi_dec[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.sw_rd) begin
            rda_reg <= mem[lo_reg];
            rdb_reg <= mem[hi_reg];
        end else if (cmd.mid_rd) begin
            rda_reg <= mem[mid_full[ADDR_W-1:0]];
            rdb_reg <= mem[cnt_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        status_reg <= status_next;
        pop_ok_reg <= pop_ok_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        if (cmd.latch) begin
            op_reg  <= in_mode;
            val_reg <= in_value;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            out_status    <= status_reg;
            out_popped    <= pop_ok_reg ? rdb_reg :
                             (status_reg == ST_EMPTY) ? POP_EMPTY_WORD : '0;
            out_middle    <= (cnt_reg != '0) ? rda_reg : '0;
            out_mid_valid <= (cnt_reg != '0);
            out_count     <= ENTRY_COUNT_W'(cnt_reg);
        end
    end

    assign m_tvalid = tvalid_reg;

endmodule

`default_nettype wire

// ----- src/swmhr_checker.sv -----
// ----------------------------------------------------------------------------
// swmhr_checker
// port-level checks on the stack block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "stack_with_middle_and_half_reverse_top_defines.svh"

module swmhr_checker
    import swmhr_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic [MODE_W-1:0]     s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic [STATUS_W-1:0]   m_tuser
);

    logic s_fire;
    logic m_stall;

    assign s_fire  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    // held result stays put
    `SWM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one operation in flight
    `SWM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_fire, !s_tready)

    // pop on empty reports all ones and an empty stack
    `SWM_ASSERT_NOW(a_pop_empty, aclk, aresetn, m_tvalid && (m_tuser == ST_EMPTY),
        (m_tdata[31:0] == POP_EMPTY_WORD) && !m_tdata[64] && (m_tdata[69:65] == 5'd0))

    // full push leaves a nonempty stack and no popped word
    `SWM_ASSERT_NOW(a_push_full, aclk, aresetn, m_tvalid && (m_tuser == ST_FULL),
        m_tdata[64] && (m_tdata[31:0] == '0))

    // refused reversal means fewer than two entries
    `SWM_ASSERT_NOW(a_rev_few, aclk, aresetn, m_tvalid && (m_tuser == ST_FEW),
        (m_tdata[69:65] < 5'd2) && (m_tdata[31:0] == '0))

endmodule

bind stack_with_middle_and_half_reverse_top swmhr_checker u_swmhr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/sv/stack_op_checker.sv -----
// ----------------------------------------------------------------------------
// stack_op_checker
// watches both stream channels of the stack block, keeps its own copy of the
// stack, predicts the result of every accepted operation and compares each
// result transaction field by field against the oldest prediction
// ----------------------------------------------------------------------------
module stack_op_checker
    import swmhr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]    s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]  m_tuser,
    output int unsigned          error_count,
    output int unsigned          outcomes_left
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [WORD_W-1:0]        popped;
        logic [WORD_W-1:0]        middle;
        logic                     mid_ok;
        logic [ENTRY_COUNT_W-1:0] fill;
    } stack_outcome_t;

    logic [WORD_W-1:0] shadow_words [STACK_DEPTH];
    int unsigned       shadow_fill;
    stack_outcome_t    outcome_q [$];

    function automatic stack_outcome_t apply_stack_op(input logic [MODE_W-1:0] op,
                                                      input logic [WORD_W-1:0] word);
        stack_outcome_t    res;
        logic [WORD_W-1:0] tmp;
        int unsigned       half;
        int unsigned       i;
        res = '0;
        case (op)
            MODE_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[shadow_fill] = word;
                    shadow_fill++;
                end
            end
            MODE_POP: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                    res.popped = POP_EMPTY_WORD;
                end else begin
                    shadow_fill--;
                    res.popped = shadow_words[shadow_fill];
                end
            end
            MODE_REV: begin
                if (shadow_fill < 2) begin
                    res.status = ST_FEW;
                end else begin
                    half = shadow_fill / 2;
                    for (i = 0; i < half / 2; i++) begin
                        tmp = shadow_words[i];
                        shadow_words[i] = shadow_words[half - 1 - i];
                        shadow_words[half - 1 - i] = tmp;
                    end
                end
            end
            default: begin
                // unused mode code leaves the stack alone
            end
        endcase
        if (shadow_fill > 0) begin
            res.middle = shadow_words[(shadow_fill - 1) / 2];
            res.mid_ok = 1'b1;
        end
        res.fill = ENTRY_COUNT_W'(shadow_fill);
        return res;
    endfunction

    function automatic void note_error(input string msg);
        if (error_count < REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
        error_count++;
    endfunction

    always @(posedge aclk) begin
        stack_outcome_t want;
        stack_outcome_t got;
        if (!aresetn) begin
            outcome_q.delete();
            shadow_fill = 0;
            error_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(apply_stack_op(s_tuser, s_tdata[WORD_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.popped = m_tdata[31:0];
                got.middle = m_tdata[63:32];
                got.mid_ok = m_tdata[64];
                got.fill   = m_tdata[69:65];
                if (outcome_q.size() == 0) begin
                    note_error($sformatf("result transaction with none pending: %p", got));
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        note_error($sformatf({"mismatch (expected/actual): status %0d/%0d ",
                            "popped %h/%h middle %h/%h valid %0b/%0b count %0d/%0d"},
                            want.status, got.status, want.popped, got.popped,
                            want.middle, got.middle, want.mid_ok, got.mid_ok,
                            want.fill, got.fill));
                    end
                end
            end
        end
        outcomes_left = outcome_q.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives operations into the stack block and gives the verdict: a directed
// pass over the edge cases (empty, single entry, full, extreme words, unused
// mode) followed by biased random traffic with random idling on both sides
// and one long hold-off on the result side
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import swmhr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned RANDOM_OPS   = 1210;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    int unsigned error_count;
    int unsigned outcomes_left;
    int unsigned cycle_count = 0;
    bit          long_hold_go = 1'b0;
    bit          busy_phase = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    stack_with_middle_and_half_reverse_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    stack_op_checker op_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .outcomes_left (outcomes_left)
    );

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            4:       return WORD_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic [MODE_W-1:0] op, input logic [WORD_W-1:0] word);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        gap = busy_phase ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side
    initial begin
        int unsigned run_len;
        int unsigned stall_len;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold_go && !long_hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
            end
            run_len = $urandom_range(1, 24);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = busy_phase ? 0 : idle_len();
            if (stall_len != 0) begin
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    // operation side
    initial begin
        int unsigned       push_pct;
        int unsigned       r;
        logic [MODE_W-1:0] op;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_PUSH;
        aresetn  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty stack, single entry, extreme words, unused mode
        send_op(MODE_POP, '0);
        send_op(MODE_REV, '0);
        send_op(MODE_UNUSED, '1);
        send_op(MODE_PUSH, 32'h8000_0000);
        send_op(MODE_REV, '0);
        send_op(MODE_PUSH, 32'h7fff_ffff);
        send_op(MODE_PUSH, '1);
        send_op(MODE_PUSH, '0);
        send_op(MODE_REV, '0);
        // fill up, then push, reverse and send the unused mode at full
        for (int k = 4; k < STACK_DEPTH; k++) begin
            send_op(MODE_PUSH, $urandom);
        end
        send_op(MODE_PUSH, 32'h1234_5678);
        send_op(MODE_REV, '0);
        send_op(MODE_UNUSED, '0);

        long_hold_go = 1'b1;
        push_pct = 50;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            if (n == 500) busy_phase = 1'b1;
            if (n == 650) busy_phase = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                op = MODE_UNUSED;
            end else if (r < 15) begin
                op = MODE_REV;
            end else if (r < 15 + push_pct * 85 / 100) begin
                op = MODE_PUSH;
            end else begin
                op = MODE_POP;
            end
            send_op(op, rand_word());
        end
        s_tvalid <= 1'b0;

        // let the checker record the last accepted transaction
        @(posedge aclk);
        while (outcomes_left != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
